/* design/hie_pkg.sv */
// Shared types, codes and constants for the Hermite interpolation engine.
package hie_pkg;

  localparam int unsigned MAX_NODES_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned ACC_W         = 48;
  localparam int unsigned DEN_W         = 33;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SAT       = 2'd1;
  localparam logic [1:0] STATUS_NOT_READY = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] abscissa;
    logic signed [VAL_W-1:0] sample_value;
    logic                    last_sample;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] interpolated_value;
    logic [1:0]              status;
  } result_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_DIV_GO,
    OP_DER_GO,
    OP_DER_DIV,
    OP_DER_TAKE,
    OP_WR_DIV,
    OP_WR_DER,
    OP_WR_ZERO,
    OP_READY,
    OP_Q_GO,
    OP_Q_NONE,
    OP_MUL_PREP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ACC,
    OP_Q_FIN
  } op_e;

  typedef struct packed {
    logic ready;
    logic div_done;
    logic is_deriv;
    logic z_ne;
  } stat_t;

endpackage

/* design/hie_divider.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
module hie_divider import hie_pkg::*; #(
  parameter int unsigned DIVIDEND_W = 64,
  parameter int unsigned DIVISOR_W  = 33
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CW-1:0]         cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  den_q;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  fits;

  assign rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? DIVISOR_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* design/hie_datapath.sv */
// Node store, divided-difference table, shared divider and Horner multiplier.
module hie_datapath import hie_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_NODES),
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  op_e              op_i,
  input  logic [IDX_W-1:0] j_i,
  input  logic [IDX_W-1:0] k_i,
  input  logic [CNT_W-1:0] f_i,
  input  item_t            item_i,
  output stat_t            stat_o,
  output logic [CNT_W-1:0] cnt_o,
  output result_t          result_o,
  output logic             strobe_o
);

  localparam int unsigned DIV_W  = ACC_W + FRAC_BITS;
  localparam int unsigned HALF_W = ACC_W / 2;
  localparam int unsigned PP_W   = HALF_W + DEN_W;
  localparam int unsigned PROD_W = ACC_W + DEN_W;
  localparam logic signed [ACC_W-1:0] LIM_POS = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] LIM_NEG = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] v);
    if (v[ACC_W] != v[ACC_W-1]) begin
      return v[ACC_W] ? LIM_NEG : LIM_POS;
    end
    return v[ACC_W-1:0];
  endfunction

  // storage
  logic signed [VAL_W-1:0] z_q    [MAX_NODES];
  logic signed [VAL_W-1:0] s_q    [MAX_NODES];
  logic [IDX_W-1:0]        run_q  [MAX_NODES];
  logic signed [ACC_W-1:0] diff_q [MAX_NODES];
  logic signed [ACC_W-1:0] coef_q [MAX_NODES];

  logic [CNT_W-1:0]        cnt_q;
  logic                    ready_q;
  logic signed [VAL_W-1:0] last_z_q;
  logic [IDX_W-1:0]        last_run_q;

  // build state
  logic                    quo_neg_q;
  logic                    der_neg_q;
  logic [VAL_W-1:0]        der_mag_q;

  // query state
  logic signed [VAL_W-1:0] x_q;
  logic signed [ACC_W-1:0] sum_q;
  logic                    hsat_q;
  logic [ACC_W-1:0]        amag_q;
  logic [DEN_W-1:0]        dmag_q;
  logic                    pneg_q;
  logic [PROD_W-1:0]       prod_q;

  logic                    strobe_q;
  result_t                 res_q;

  // load
  logic [CNT_W-1:0] base;
  logic [IDX_W-1:0] base_idx;
  logic             room;
  logic [IDX_W-1:0] new_run;

  assign base     = ready_q ? '0 : cnt_q;
  assign base_idx = base[IDX_W-1:0];
  assign room     = base < CNT_W'(MAX_NODES);
  assign new_run  = ((base != '0) && (item_i.abscissa == last_z_q)) ? last_run_q : base_idx;

  // column step
  logic [IDX_W-1:0]        jk;
  logic [IDX_W-1:0]        j1;
  logic [IDX_W-1:0]        ridx;
  logic signed [ACC_W:0]   dsub;
  logic signed [ACC_W-1:0] num;
  logic [ACC_W-1:0]        num_mag;
  logic signed [DEN_W-1:0] den;
  logic [DEN_W-1:0]        den_mag;
  logic [VAL_W-1:0]        src;

  assign jk      = j_i + k_i;
  assign j1      = j_i + 1'b1;
  assign ridx    = run_q[j_i] + k_i;
  assign dsub    = {diff_q[j1][ACC_W-1], diff_q[j1]} - {diff_q[j_i][ACC_W-1], diff_q[j_i]};
  assign num     = sat48(dsub);
  assign num_mag = num[ACC_W-1] ? (~num + 1'b1) : num;
  assign den     = {z_q[jk][VAL_W-1], z_q[jk]} - {z_q[j_i][VAL_W-1], z_q[j_i]};
  assign den_mag = den[DEN_W-1] ? (~den + 1'b1) : den;
  assign src     = s_q[ridx];

  // shared divider
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] quotient;

  assign div_start    = (op_i == OP_DIV_GO) || (op_i == OP_DER_DIV);
  assign div_dividend = (op_i == OP_DER_DIV) ? DIV_W'(der_mag_q)
                                             : {num_mag, {FRAC_BITS{1'b0}}};
  assign div_divisor  = (op_i == OP_DER_DIV) ? DEN_W'(f_i) : den_mag;

  hie_divider #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  logic                    div_sat;
  logic signed [ACC_W-1:0] div_val;
  logic signed [ACC_W-1:0] der_val;
  logic signed [ACC_W-1:0] wr_val;

  assign div_sat = |quotient[DIV_W-1:ACC_W-1];
  always_comb begin
    if (quo_neg_q) begin
      div_val = div_sat ? LIM_NEG : -$signed(quotient[ACC_W-1:0]);
    end else begin
      div_val = div_sat ? LIM_POS : $signed(quotient[ACC_W-1:0]);
    end
  end
  assign der_val = der_neg_q ? -$signed(ACC_W'(der_mag_q)) : $signed(ACC_W'(der_mag_q));

  always_comb begin
    case (op_i)
      OP_WR_DIV: wr_val = div_val;
      OP_WR_DER: wr_val = der_val;
      default:   wr_val = '0;
    endcase
  end

  // Horner step
  logic signed [DEN_W-1:0] d;
  logic [HALF_W-1:0]       mul_a;
  logic [PP_W-1:0]         pp;
  logic [PROD_W-1:0]       pmag;
  logic [PROD_W-1:0]       plimit;
  logic                    psat;
  logic signed [ACC_W-1:0] pval;
  logic signed [ACC_W:0]   s49;
  logic                    s_ovf;
  logic                    out_ovf;

  assign d      = {x_q[VAL_W-1], x_q} - {z_q[j_i][VAL_W-1], z_q[j_i]};
  assign mul_a  = (op_i == OP_MUL_HI) ? amag_q[ACC_W-1:HALF_W] : amag_q[HALF_W-1:0];
  assign pp     = mul_a * dmag_q;
  assign pmag   = prod_q >> FRAC_BITS;
  assign plimit = pneg_q ? (PROD_W'(1) << (ACC_W - 1)) : PROD_W'(LIM_POS);
  assign psat   = pmag > plimit;
  always_comb begin
    if (psat) begin
      pval = pneg_q ? LIM_NEG : LIM_POS;
    end else begin
      pval = pneg_q ? -$signed(pmag[ACC_W-1:0]) : $signed(pmag[ACC_W-1:0]);
    end
  end
  assign s49     = {coef_q[j_i][ACC_W-1], coef_q[j_i]} + {pval[ACC_W-1], pval};
  assign s_ovf   = s49[ACC_W] != s49[ACC_W-1];
  assign out_ovf = !((&sum_q[ACC_W-1:VAL_W-1]) || !(|sum_q[ACC_W-1:VAL_W-1]));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ready_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (op_i == OP_Q_NONE) || (op_i == OP_Q_FIN);
      if (op_i == OP_LOAD) begin
        ready_q <= 1'b0;
        cnt_q   <= room ? base + 1'b1 : base;
      end else if (op_i == OP_READY) begin
        ready_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        if (room) begin
          z_q[base_idx]   <= item_i.abscissa;
          s_q[base_idx]   <= item_i.sample_value;
          run_q[base_idx] <= new_run;
          last_z_q        <= item_i.abscissa;
          last_run_q      <= new_run;
        end
      end
      OP_INIT: begin
        diff_q[j_i] <= ACC_W'(s_q[run_q[j_i]]);
        if (j_i == '0) begin
          coef_q[0] <= ACC_W'(s_q[run_q[j_i]]);
        end
      end
      OP_DIV_GO: quo_neg_q <= num[ACC_W-1] ^ den[DEN_W-1];
      OP_DER_GO: begin
        der_neg_q <= src[VAL_W-1];
        der_mag_q <= src[VAL_W-1] ? (~src + 1'b1) : src;
      end
      OP_DER_TAKE: der_mag_q <= quotient[VAL_W-1:0];
      OP_WR_DIV, OP_WR_DER, OP_WR_ZERO: begin
        diff_q[j_i] <= wr_val;
        if (j_i == '0) begin
          coef_q[k_i] <= wr_val;
        end
      end
      OP_Q_GO: begin
        x_q    <= item_i.abscissa;
        sum_q  <= coef_q[IDX_W'(cnt_q - 1'b1)];
        hsat_q <= 1'b0;
      end
      OP_Q_NONE: begin
        res_q.interpolated_value <= '0;
        res_q.status             <= STATUS_NOT_READY;
      end
      OP_MUL_PREP: begin
        amag_q <= sum_q[ACC_W-1] ? (~sum_q + 1'b1) : sum_q;
        dmag_q <= d[DEN_W-1] ? (~d + 1'b1) : d;
        pneg_q <= sum_q[ACC_W-1] ^ d[DEN_W-1];
      end
      OP_MUL_LO: prod_q <= PROD_W'(pp);
      OP_MUL_HI: prod_q <= prod_q + (PROD_W'(pp) << HALF_W);
      OP_ACC: begin
        sum_q  <= sat48(s49);
        hsat_q <= hsat_q | psat | s_ovf;
      end
      OP_Q_FIN: begin
        if (out_ovf) begin
          res_q.interpolated_value <= sum_q[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                     : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
          res_q.interpolated_value <= sum_q[VAL_W-1:0];
        end
        res_q.status <= (hsat_q || out_ovf) ? STATUS_SAT : STATUS_OK;
      end
      default: ;
    endcase
  end

  assign stat_o.ready    = ready_q;
  assign stat_o.div_done = div_done;
  assign stat_o.is_deriv = run_q[jk] <= j_i;
  assign stat_o.z_ne     = z_q[jk] != z_q[j_i];
  assign cnt_o           = cnt_q;
  assign result_o        = res_q;
  assign strobe_o        = strobe_q;

endmodule

/* design/hie_controller.sv */
// Sequencer for loading, the divided-difference build and Horner evaluation.
module hie_controller import hie_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_NODES),
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             mode_i,
  input  logic             last_i,
  input  stat_t            stat_i,
  input  logic [CNT_W-1:0] cnt_i,
  output op_e              op_o,
  output logic [IDX_W-1:0] j_o,
  output logic [IDX_W-1:0] k_o,
  output logic [CNT_W-1:0] f_o,
  output logic             busy_o
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_INIT     = 12'b0000_0000_0010,
    S_COL      = 12'b0000_0000_0100,
    S_DIV_WAIT = 12'b0000_0000_1000,
    S_DER_CHK  = 12'b0000_0001_0000,
    S_DER_WAIT = 12'b0000_0010_0000,
    S_BUILT    = 12'b0000_0100_0000,
    S_PREP     = 12'b0000_1000_0000,
    S_MUL_LO   = 12'b0001_0000_0000,
    S_MUL_HI   = 12'b0010_0000_0000,
    S_ACC      = 12'b0100_0000_0000,
    S_Q_FIN    = 12'b1000_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] j_q, j_d, k_q, k_d;
  logic [CNT_W-1:0] f_q, f_d;

  // next (k, j) after a column entry is written
  state_e           adv_state;
  logic [IDX_W-1:0] adv_j, adv_k;

  always_comb begin
    adv_j     = j_q + 1'b1;
    adv_k     = k_q;
    adv_state = S_COL;
    if (CNT_W'(j_q) + CNT_W'(k_q) + 1'b1 == cnt_i) begin
      adv_j = '0;
      adv_k = k_q + 1'b1;
      if (CNT_W'(k_q) + 1'b1 >= cnt_i) begin
        adv_state = S_BUILT;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    k_d     = k_q;
    f_d     = f_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (mode_i == MODE_LOAD) begin
            op_o = OP_LOAD;
            if (last_i) begin
              j_d     = '0;
              state_d = S_INIT;
            end
          end else if (!stat_i.ready) begin
            op_o = OP_Q_NONE;
          end else begin
            op_o = OP_Q_GO;
            if (cnt_i == CNT_W'(1)) begin
              state_d = S_Q_FIN;
            end else begin
              j_d     = IDX_W'(cnt_i - CNT_W'(2));
              state_d = S_PREP;
            end
          end
        end
      end
      S_INIT: begin
        op_o = OP_INIT;
        j_d  = j_q + 1'b1;
        if (CNT_W'(j_q) + 1'b1 == cnt_i) begin
          j_d     = '0;
          k_d     = IDX_W'(1);
          state_d = (cnt_i == CNT_W'(1)) ? S_BUILT : S_COL;
        end
      end
      S_COL: begin
        if (stat_i.is_deriv) begin
          op_o    = OP_DER_GO;
          f_d     = CNT_W'(2);
          state_d = S_DER_CHK;
        end else if (stat_i.z_ne) begin
          op_o    = OP_DIV_GO;
          state_d = S_DIV_WAIT;
        end else begin
          op_o    = OP_WR_ZERO;
          j_d     = adv_j;
          k_d     = adv_k;
          state_d = adv_state;
        end
      end
      S_DIV_WAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_WR_DIV;
          j_d     = adv_j;
          k_d     = adv_k;
          state_d = adv_state;
        end
      end
      S_DER_CHK: begin
        if (f_q <= CNT_W'(k_q)) begin
          op_o    = OP_DER_DIV;
          state_d = S_DER_WAIT;
        end else begin
          op_o    = OP_WR_DER;
          j_d     = adv_j;
          k_d     = adv_k;
          state_d = adv_state;
        end
      end
      S_DER_WAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_DER_TAKE;
          f_d     = f_q + 1'b1;
          state_d = S_DER_CHK;
        end
      end
      S_BUILT: begin
        op_o    = OP_READY;
        state_d = S_IDLE;
      end
      S_PREP: begin
        op_o    = OP_MUL_PREP;
        state_d = S_MUL_LO;
      end
      S_MUL_LO: begin
        op_o    = OP_MUL_LO;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        op_o    = OP_MUL_HI;
        state_d = S_ACC;
      end
      S_ACC: begin
        op_o = OP_ACC;
        if (j_q == '0) begin
          state_d = S_Q_FIN;
        end else begin
          j_d     = j_q - 1'b1;
          state_d = S_PREP;
        end
      end
      S_Q_FIN: begin
        op_o    = OP_Q_FIN;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
      k_q     <= '0;
      f_q     <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      k_q     <= k_d;
      f_q     <= f_d;
    end
  end

  assign j_o    = j_q;
  assign k_o    = k_q;
  assign f_o    = f_q;
  assign busy_o = state_q != S_IDLE;

endmodule

/* design/hermite_interpolation_engine.sv */
// Hermite interpolation engine: Newton divided differences and Horner evaluation in Q16.16.
// Loads without the last mark and queries before a build are handled from idle; busy stays low.
// The last load item runs the build: a seed pass over all n nodes, then per table entry a zero
// write, one divide, or for an order-k derivative divides by 2 up to k; then a ready step.
// Query: per node after the first, prepare, 24x33 multiply of low and high halves, accumulate.
// Reset clears node count, ready flag and sequencer; result strobes cannot be stalled.
module hermite_interpolation_engine import hie_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output result_t result_o,
  output logic    result_strobe_o
);

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);

  // controller to datapath: operation and table indices
  op_e              op;
  logic [IDX_W-1:0] j_idx;
  logic [IDX_W-1:0] k_idx;
  logic [CNT_W-1:0] f_cnt;
  // datapath to controller
  stat_t            stat;
  logic [CNT_W-1:0] node_cnt;

  hie_controller #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (item_i.mode),
    .last_i  (item_i.last_sample),
    .stat_i  (stat),
    .cnt_i   (node_cnt),
    .op_o    (op),
    .j_o     (j_idx),
    .k_o     (k_idx),
    .f_o     (f_cnt),
    .busy_o  (busy)
  );

  hie_datapath #(
    .MAX_NODES (MAX_NODES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .j_i      (j_idx),
    .k_i      (k_idx),
    .f_i      (f_cnt),
    .item_i   (item_i),
    .stat_o   (stat),
    .cnt_o    (node_cnt),
    .result_o (result_o),
    .strobe_o (result_strobe_o)
  );

endmodule
